// ----- hdl/fbfl_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfl_pkg - shared types and constants of the fixed block free list allocator
// widths, codes and register reset values used by all modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbfl_pkg;

    // default built depth of the pool
    localparam int MAX_BLOCKS_DEF = 1024;

    // field widths
    localparam int MODE_W     = 2;
    localparam int REQ_BYTES_W = 16;
    localparam int REQ_ALIGN_W = 13;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int NUM_W      = 10;
    localparam int POOL_BLK_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // stream widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    // quotient bits of a release: the quotient stays below 2^POOL_BLK_W
    localparam int QUOT_W = POOL_BLK_W;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_REQ  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALIGN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 2'd3;

    // register reset values
    localparam logic [ADDR_W-1:0]      RST_POOL_BASE   = 32'd0;
    localparam logic [REQ_BYTES_W-1:0] RST_BLOCK_BYTES = 16'd16;
    localparam logic [REQ_ALIGN_W-1:0] RST_BLOCK_ALIGN = 13'd8;
    localparam logic [POOL_BLK_W-1:0]  RST_POOL_BLOCKS = 11'd1024;

    // shared adder request and response
    typedef struct packed {
        logic              sub;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result;
        logic              carry;   // on subtract: a >= b
    } alu_rsp_t;

endpackage

// ----- hdl/fbfl_alu.sv -----
// ----------------------------------------------------------------------------
// fbfl_alu - shared add / subtract-compare unit
// one 32-bit adder used for address sums, range compares and division steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbfl_alu (
    input  fbfl_pkg::alu_req_t req,
    output fbfl_pkg::alu_rsp_t rsp
);

    logic [fbfl_pkg::ADDR_W:0] sum;
    logic [fbfl_pkg::ADDR_W-1:0] operand;

    assign operand = req.sub ? ~req.b : req.b;
    assign sum = {1'b0, req.a} + {1'b0, operand}
                 + {{fbfl_pkg::ADDR_W{1'b0}}, req.sub};

    assign rsp.result = sum[fbfl_pkg::ADDR_W-1:0];
    assign rsp.carry  = sum[fbfl_pkg::ADDR_W];

endmodule

// ----- hdl/fbfl_link_mem.sv -----
// ----------------------------------------------------------------------------
// fbfl_link_mem - free list link memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbfl_link_mem #(
    parameter int DEPTH = fbfl_pkg::MAX_BLOCKS_DEF,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/fixed_block_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top - fixed size block pool with free list
// hands out and takes back equal-sized blocks through a linked free list
// ----------------------------------------------------------------------------
// A request carries a mode in s_tuser: allocate pops the free list head and
// returns pool_base + index * block_bytes, release checks the address and
// pushes its block index back, clear relinks the blocks in use in ascending order.
// Every request gives exactly one result transfer. The block takes one
// request at a time and every step runs through a single shared 32-bit
// adder. An allocation runs one shift-add multiply step per bit of the
// block index (at least one step), a release runs offset, range compare,
// 11 restoring division steps and check, and a clear rewrites the link
// memory over the blocks in use, one entry per cycle; each then hands its
// result to the output register. A rejected allocation, an allocation on
// an empty list and the unused mode go straight to that hand-off, and a
// release far out of range stops after the range compare. After reset the
// same relink pass runs over min(1024, MAX_BLOCKS) entries while s_tready
// stays low; configuration writes are taken meanwhile. A finished result
// sits in the output register while the next request is accepted; a
// further result waits while that register is still held by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_top #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // request_bytes[15:0], request_align[28:16], release_address[60:29]
    input  logic [fbfl_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode[1:0]
    input  logic [fbfl_pkg::MODE_W-1:0]         s_tuser,

    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // block_address[31:0], block_number[41:32]
    output logic [fbfl_pkg::M_TDATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [fbfl_pkg::STATUS_W-1:0]       m_tuser,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int QW    = fbfl_pkg::QUOT_W;
    localparam int DCW   = $clog2(QW);
    localparam int AW    = fbfl_pkg::ADDR_W;
    // blocks relinked by the pass after reset
    localparam logic [CNT_W-1:0] RST_N =
        CNT_W'((MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_MUL,
        S_OFFSET,
        S_RANGE,
        S_DIV,
        S_RCHECK,
        S_DONE
    } state_t;

    // payload fields of the request
    logic [fbfl_pkg::MODE_W-1:0]      in_mode;
    logic [fbfl_pkg::REQ_BYTES_W-1:0] in_req_bytes;
    logic [fbfl_pkg::REQ_ALIGN_W-1:0] in_req_align;
    logic [AW-1:0]                    in_rel_addr;

    assign in_mode      = s_tuser;
    assign in_req_bytes = s_tdata[15:0];
    assign in_req_align = s_tdata[28:16];
    assign in_rel_addr  = s_tdata[60:29];

    // configuration registers
    logic [AW-1:0]                     pool_base_reg;
    logic [fbfl_pkg::REQ_BYTES_W-1:0]  block_bytes_reg;
    logic [fbfl_pkg::REQ_ALIGN_W-1:0]  block_align_reg;
    logic [fbfl_pkg::POOL_BLK_W-1:0]   pool_blocks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg   <= fbfl_pkg::RST_POOL_BASE;
            block_bytes_reg <= fbfl_pkg::RST_BLOCK_BYTES;
            block_align_reg <= fbfl_pkg::RST_BLOCK_ALIGN;
            pool_blocks_reg <= fbfl_pkg::RST_POOL_BLOCKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fbfl_pkg::CFG_POOL_BASE: begin
                    pool_base_reg <= cfg_wr_data;
                end
                fbfl_pkg::CFG_BLOCK_BYTES: begin
                    block_bytes_reg <= cfg_wr_data[fbfl_pkg::REQ_BYTES_W-1:0];
                end
                fbfl_pkg::CFG_BLOCK_ALIGN: begin
                    block_align_reg <= cfg_wr_data[fbfl_pkg::REQ_ALIGN_W-1:0];
                end
                fbfl_pkg::CFG_POOL_BLOCKS: begin
                    pool_blocks_reg <= cfg_wr_data[fbfl_pkg::POOL_BLK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pool_blocks clamped to the built depth
    logic [CNT_W-1:0] blocks_in_use;
    assign blocks_in_use = (32'(pool_blocks_reg) > 32'(MAX_BLOCKS)) ?
                           CNT_W'(MAX_BLOCKS) : CNT_W'(pool_blocks_reg);

    // sequencer and datapath registers
    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               head_reg, head_next;
    logic                           head_valid_reg, head_valid_next;
    logic [AW-1:0]                  acc_reg, acc_next;        // sum / remainder
    logic [AW-1:0]                  mcand_reg, mcand_next;    // shifted block size
    logic [IDX_W-1:0]               mplier_reg, mplier_next;  // index bits left
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [AW-1:0]                  dvs_reg, dvs_next;        // shifted divisor
    logic [QW-1:0]                  quot_reg, quot_next;
    logic [DCW-1:0]                 dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]               sweep_cnt_reg, sweep_cnt_next;
    logic [CNT_W-1:0]               sweep_n_reg, sweep_n_next;
    logic                           sweep_reply_reg, sweep_reply_next;
    logic [fbfl_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [AW-1:0]                  res_addr_reg, res_addr_next;
    logic [fbfl_pkg::NUM_W-1:0]     res_num_reg, res_num_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [fbfl_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [AW-1:0]                  m_addr_reg, m_addr_next;
    logic [fbfl_pkg::NUM_W-1:0]     m_num_reg, m_num_next;

    // shared adder
    fbfl_pkg::alu_req_t alu_req;
    fbfl_pkg::alu_rsp_t alu_rsp;

    fbfl_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // link memory: each entry is {valid, next index}
    logic             mem_rd_en;
    logic [IDX_W:0]   mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [IDX_W:0]   mem_wr_data;

    fbfl_link_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IDX_W),
        .DW    (IDX_W + 1)
    ) u_link_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (head_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    logic             s_accept;
    logic             bad_req;
    logic             out_free;
    logic [CNT_W:0]   sweep_cnt_inc;
    logic             release_ok;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign bad_req = (in_req_bytes == '0) || (in_req_bytes > block_bytes_reg)
                     || (in_req_align > block_align_reg);

    assign sweep_cnt_inc = {1'b0, sweep_cnt_reg} + {{CNT_W{1'b0}}, 1'b1};

    // release passes when the remainder is zero and the index is in use
    assign release_ok = (acc_reg == '0) && (32'(quot_reg) < 32'(blocks_in_use));

    // adder operand selection per step
    always_comb begin
        alu_req.sub = 1'b0;
        alu_req.a   = acc_reg;
        alu_req.b   = '0;
        unique case (state_reg)
            S_MUL: begin
                alu_req.b = mplier_reg[0] ? mcand_reg : '0;
            end
            S_OFFSET: begin
                alu_req.sub = 1'b1;
                alu_req.b   = pool_base_reg;
            end
            S_RANGE: begin
                alu_req.sub = 1'b1;
                alu_req.b   = AW'(block_bytes_reg) << QW;
            end
            S_DIV: begin
                alu_req.sub = 1'b1;
                alu_req.b   = dvs_reg;
            end
            default: begin
            end
        endcase
    end

    // link memory access
    always_comb begin
        mem_rd_en   = s_accept && (in_mode == fbfl_pkg::MODE_ALLOC) && !bad_req
                      && head_valid_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = sweep_cnt_reg[IDX_W-1:0];
        mem_wr_data = {(sweep_cnt_inc < {1'b0, sweep_n_reg}),
                       IDX_W'(sweep_cnt_inc)};
        unique case (state_reg)
            S_SWEEP: begin
                mem_wr_en = 1'b1;
            end
            S_RCHECK: begin
                mem_wr_en   = release_ok;
                mem_wr_addr = IDX_W'(quot_reg);
                mem_wr_data = {head_valid_reg, head_reg};
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        head_valid_next  = head_valid_reg;
        acc_next         = acc_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        idx_next         = idx_reg;
        dvs_next         = dvs_reg;
        quot_next        = quot_reg;
        dcnt_next        = dcnt_reg;
        sweep_cnt_next   = sweep_cnt_reg;
        sweep_n_next     = sweep_n_reg;
        sweep_reply_next = sweep_reply_reg;
        res_status_next  = res_status_reg;
        res_addr_next    = res_addr_reg;
        res_num_next     = res_num_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_addr_next      = m_addr_reg;
        m_num_next       = m_num_reg;

        unique case (state_reg)
            S_SWEEP: begin
                sweep_cnt_next = sweep_cnt_inc[CNT_W-1:0];
                if (sweep_cnt_inc >= {1'b0, sweep_n_reg}) begin
                    head_next       = '0;
                    head_valid_next = 1'b1;
                    res_status_next = fbfl_pkg::ST_OK;
                    res_addr_next   = '0;
                    res_num_next    = '0;
                    state_next      = sweep_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    res_status_next = fbfl_pkg::ST_OK;
                    res_addr_next   = '0;
                    res_num_next    = '0;
                    state_next      = S_DONE;
                    unique case (in_mode)
                        fbfl_pkg::MODE_ALLOC: begin
                            if (bad_req) begin
                                res_status_next = fbfl_pkg::ST_BAD_REQ;
                            end else if (!head_valid_reg) begin
                                res_status_next = fbfl_pkg::ST_EMPTY;
                            end else begin
                                acc_next    = pool_base_reg;
                                mcand_next  = AW'(block_bytes_reg);
                                mplier_next = head_reg;
                                idx_next    = head_reg;
                                state_next  = S_MUL;
                            end
                        end
                        fbfl_pkg::MODE_RELEASE: begin
                            acc_next   = in_rel_addr;
                            state_next = S_OFFSET;
                        end
                        fbfl_pkg::MODE_CLEAR: begin
                            sweep_cnt_next   = '0;
                            sweep_n_next     = blocks_in_use;
                            sweep_reply_next = 1'b1;
                            if (blocks_in_use == '0) begin
                                head_next       = '0;
                                head_valid_next = 1'b0;
                            end else begin
                                state_next = S_SWEEP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MUL: begin
                // shift-add multiply, stops once no index bits are left
                acc_next    = alu_rsp.result;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if ((mplier_reg >> 1) == '0) begin
                    res_status_next = fbfl_pkg::ST_OK;
                    res_addr_next   = alu_rsp.result;
                    res_num_next    = fbfl_pkg::NUM_W'(idx_reg);
                    head_next       = mem_rd_data[IDX_W-1:0];
                    head_valid_next = mem_rd_data[IDX_W];
                    state_next      = S_DONE;
                end
            end
            S_OFFSET: begin
                acc_next   = alu_rsp.result;
                state_next = S_RANGE;
            end
            S_RANGE: begin
                // offset at or past block_bytes * 2^QW can never be in range
                if ((block_bytes_reg == '0) || alu_rsp.carry) begin
                    res_status_next = fbfl_pkg::ST_BAD_ADDR;
                    state_next      = S_DONE;
                end else begin
                    dvs_next   = AW'(block_bytes_reg) << (QW - 1);
                    quot_next  = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (alu_rsp.carry) begin
                    acc_next = alu_rsp.result;
                end
                quot_next = {quot_reg[QW-2:0], alu_rsp.carry};
                dvs_next  = dvs_reg >> 1;
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(QW - 1)) begin
                    state_next = S_RCHECK;
                end
            end
            S_RCHECK: begin
                if (release_ok) begin
                    head_next       = IDX_W'(quot_reg);
                    head_valid_next = 1'b1;
                    res_num_next    = fbfl_pkg::NUM_W'(quot_reg);
                end else begin
                    res_status_next = fbfl_pkg::ST_BAD_ADDR;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    m_num_next    = res_num_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_SWEEP;
            head_reg        <= '0;
            head_valid_reg  <= 1'b0;
            sweep_cnt_reg   <= '0;
            sweep_n_reg     <= RST_N;
            sweep_reply_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            head_valid_reg  <= head_valid_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            sweep_n_reg     <= sweep_n_next;
            sweep_reply_reg <= sweep_reply_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        idx_reg        <= idx_next;
        dvs_reg        <= dvs_next;
        quot_reg       <= quot_next;
        dcnt_reg       <= dcnt_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_num_reg    <= res_num_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_num_reg      <= m_num_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(fbfl_pkg::M_TDATA_W - AW - fbfl_pkg::NUM_W){1'b0}},
                       m_num_reg, m_addr_reg};

endmodule

// ----- hdl/fbfl_checker.sv -----
// ----------------------------------------------------------------------------
// fbfl_checker - port level checks of the free list allocator
// watches the stream ports and is bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbfl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fbfl_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [fbfl_pkg::STATUS_W-1:0]   m_tuser
);

    // reset leaves no result and runs the relink pass before any request
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or ready right after reset");

    // one request at a time: ready drops after every accepted transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one still in work");

    // a failed request names no block
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != fbfl_pkg::ST_OK) |-> (m_tdata[41:0] == '0))
        else $error("error result carries an address or block number");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker u_fbfl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the fixed block free list allocator
// drives allocate, release, clear and unused-mode requests over the request
// stream and compares every result transfer with an in-bench model of the
// free list, across several pool settings and with random idling on both sides
// ----------------------------------------------------------------------------

module testbench;

    localparam int DEPTH       = fbfl_pkg::MAX_BLOCKS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int AW          = fbfl_pkg::ADDR_W;
    localparam int BW          = fbfl_pkg::REQ_BYTES_W;
    localparam int LW          = fbfl_pkg::REQ_ALIGN_W;
    localparam int PW          = fbfl_pkg::POOL_BLK_W;
    localparam int NW          = fbfl_pkg::NUM_W;

    // the fourth mode value has no package name: it must do nothing
    localparam logic [fbfl_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [fbfl_pkg::STATUS_W-1:0] status;
        logic [AW-1:0]                 block_address;
        logic [NW-1:0]                 block_number;
    } pool_result_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [fbfl_pkg::S_TDATA_W-1:0]  s_tdata     = '0;
    logic [fbfl_pkg::MODE_W-1:0]     s_tuser     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [fbfl_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [fbfl_pkg::STATUS_W-1:0]   m_tuser;
    logic                            cfg_wr_en   = 1'b0;
    logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [fbfl_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    // mirror of the pool registers
    logic [AW-1:0] base_addr;
    logic [BW-1:0] blk_size;
    logic [LW-1:0] blk_align_max;
    logic [PW-1:0] blk_count;

    // mirror of the free list
    logic [PW-1:0]  link_next [DEPTH];
    logic           link_valid [DEPTH];
    logic [PW-1:0]  list_head;
    logic           list_head_ok;

    pool_result_t   pending_results [$];
    logic [AW-1:0]  granted_addrs [$];

    int error_count = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit steady_flow = 1'b0;

    always #4 aclk = ~aclk;

    fixed_block_free_list_allocator_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // free list model
    // ------------------------------------------------------------------

    // blocks in use never exceed the built depth
    function automatic int unsigned blocks_active();
        return (blk_count > DEPTH) ? DEPTH : int'(blk_count);
    endfunction

    // clear: ascending chain over the blocks in use, empty list for zero
    function automatic void relink_pool();
        int unsigned n;
        n = blocks_active();
        for (int i = 0; i < DEPTH; i++) begin
            link_next[i]  = (i + 1 < n) ? PW'(i + 1) : '0;
            link_valid[i] = (i + 1 < n);
        end
        list_head    = '0;
        list_head_ok = (n != 0);
    endfunction

    function automatic pool_result_t predict_pool_result(
            input logic [fbfl_pkg::MODE_W-1:0] mode,
            input logic [BW-1:0]               req_size,
            input logic [LW-1:0]               req_align,
            input logic [AW-1:0]               rel_addr);
        pool_result_t res;
        logic [AW-1:0] offset;
        logic [63:0]   span;
        int unsigned   idx;
        res = '0;
        res.status = fbfl_pkg::ST_OK;
        case (mode)
            fbfl_pkg::MODE_ALLOC: begin
                // request checks win over an empty list
                if (req_size == 0 || req_size > blk_size || req_align > blk_align_max) begin
                    res.status = fbfl_pkg::ST_BAD_REQ;
                end else if (!list_head_ok) begin
                    res.status = fbfl_pkg::ST_EMPTY;
                end else begin
                    idx = list_head % DEPTH;
                    res.block_address = base_addr + AW'(idx) * AW'(blk_size);
                    res.block_number  = NW'(idx);
                    list_head    = link_next[idx];
                    list_head_ok = link_valid[idx];
                end
            end
            fbfl_pkg::MODE_RELEASE: begin
                offset = rel_addr - base_addr;
                span   = 64'(blocks_active()) * 64'(blk_size);
                if (blk_size == 0 || 64'(offset) >= span) begin
                    res.status = fbfl_pkg::ST_BAD_ADDR;
                end else if (offset % blk_size != 0) begin
                    res.status = fbfl_pkg::ST_BAD_ADDR;
                end else begin
                    idx = (offset / blk_size) % DEPTH;
                    link_next[idx]  = list_head;
                    link_valid[idx] = list_head_ok;
                    list_head       = PW'(idx);
                    list_head_ok    = 1'b1;
                    res.block_number = NW'(idx);
                end
            end
            fbfl_pkg::MODE_CLEAR: relink_pool();
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request transfer; valid stays up for a back-to-back follower
    task automatic send_request(input logic [fbfl_pkg::MODE_W-1:0] mode,
                                input logic [BW-1:0]               req_size,
                                input logic [LW-1:0]               req_align,
                                input logic [AW-1:0]               rel_addr);
        pool_result_t want;
        if (!steady_flow && $urandom_range(99, 0) < 16) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= fbfl_pkg::S_TDATA_W'({rel_addr, req_align, req_size});
        do @(posedge aclk); while (s_tready !== 1'b1);
        want = predict_pool_result(mode, req_size, req_align, rel_addr);
        pending_results.push_back(want);
        if (mode == fbfl_pkg::MODE_ALLOC && want.status == fbfl_pkg::ST_OK) begin
            granted_addrs.push_back(want.block_address);
        end else if (mode == fbfl_pkg::MODE_CLEAR) begin
            granted_addrs.delete();
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // writes all four registers while the block is idle; no relink happens
    task automatic apply_config(input logic [AW-1:0] base,
                                input logic [BW-1:0] size,
                                input logic [LW-1:0] align_max,
                                input logic [PW-1:0] count);
        logic [fbfl_pkg::CFG_DATA_W-1:0] vals [4];
        logic [fbfl_pkg::CFG_IDX_W-1:0]  regs [4];
        wait_for_results();
        vals = '{base, fbfl_pkg::CFG_DATA_W'(size), fbfl_pkg::CFG_DATA_W'(align_max),
                 fbfl_pkg::CFG_DATA_W'(count)};
        regs = '{fbfl_pkg::CFG_POOL_BASE, fbfl_pkg::CFG_BLOCK_BYTES,
                 fbfl_pkg::CFG_BLOCK_ALIGN, fbfl_pkg::CFG_POOL_BLOCKS};
        for (int k = 0; k < 4; k++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= regs[k];
            cfg_wr_data <= vals[k];
            @(posedge aclk);
        end
        cfg_wr_en     <= 1'b0;
        base_addr     = base;
        blk_size      = size;
        blk_align_max = align_max;
        blk_count     = count;
        granted_addrs.delete();
    endtask

    // mostly proper allocate/release traffic, plus bad requests and noise
    task automatic random_request();
        logic [BW-1:0] size;
        logic [LW-1:0] align;
        logic [AW-1:0] addr;
        int unsigned   pick, n, slot;
        pick  = $urandom_range(99, 0);
        size  = BW'($urandom());
        align = LW'($urandom_range(4096, 0));
        addr  = $urandom();
        n     = blocks_active();
        if (pick < 50) begin
            if ($urandom_range(99, 0) < 85) begin
                size  = BW'($urandom_range(blk_size, 1));
                align = ($urandom_range(9, 0) == 0) ? '0
                        : LW'($urandom_range(blk_align_max, 1));
            end else begin
                case ($urandom_range(2, 0))
                    0: size = '0;
                    1: size = (blk_size == '1) ? '0
                              : BW'($urandom_range(65535, blk_size + 1));
                    default: begin
                        if (blk_align_max < 4096)
                            align = LW'($urandom_range(4096, blk_align_max + 1));
                        else size = '0;
                    end
                endcase
            end
            send_request(fbfl_pkg::MODE_ALLOC, size, align, addr);
        end else if (pick < 88) begin
            if (granted_addrs.size() != 0 && $urandom_range(99, 0) < 80) begin
                slot = $urandom_range(granted_addrs.size() - 1, 0);
                addr = granted_addrs[slot];
                granted_addrs.delete(slot);
            end else begin
                case ($urandom_range(3, 0))
                    0: ;
                    // on the grid, possibly a block that is already free
                    1: if (n != 0) addr = base_addr + AW'($urandom_range(n - 1, 0) * blk_size);
                    // off the grid, for blocks larger than one byte
                    2: addr = base_addr + AW'($urandom_range(n, 0) * blk_size)
                              + ((blk_size > 1) ? AW'($urandom_range(blk_size - 1, 1)) : '0);
                    // past the end of the pool or just below its base
                    default: addr = ($urandom_range(1, 0) == 1)
                              ? base_addr + AW'((n + $urandom_range(3, 0)) * blk_size)
                              : base_addr - AW'(blk_size);
                endcase
            end
            send_request(fbfl_pkg::MODE_RELEASE, size, align, addr);
        end else if (pick < 91) begin
            send_request(fbfl_pkg::MODE_CLEAR, size, align, addr);
        end else if (pick < 93) begin
            send_request(MODE_UNUSED, size, align, addr);
        end else begin
            send_request(fbfl_pkg::MODE_ALLOC, size, align, addr);
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver: random stalls, a quiet stretch, and a counted long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (steady_flow) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= 16);
        end
    end

    // every result transfer against the oldest prediction
    always @(posedge aclk) begin
        pool_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $error("result transfer with nothing pending, status %0d", m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    error_count++;
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                end
                if (m_tdata[AW-1:0] !== want.block_address) begin
                    error_count++;
                    $error("block_address: expected %h, got %h",
                           want.block_address, m_tdata[AW-1:0]);
                end
                if (m_tdata[AW +: NW] !== want.block_number) begin
                    error_count++;
                    $error("block_number: expected %0d, got %0d",
                           want.block_number, m_tdata[AW +: NW]);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results pending",
                   cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // size and alignment checks on the reset settings, zero alignment, unused mode
    task automatic test_allocation_checks();
        send_request(fbfl_pkg::MODE_ALLOC, 16'd16, 13'd8, '0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd1, 13'd0, '0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd0, 13'd1, '0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd17, 13'd1, '0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd16, 13'd9, '0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'hFFFF, 13'd4096, '1);
        send_request(MODE_UNUSED, '1, '1, '1);
    endtask

    // grid, range and wrap checks on release; last block of the pool
    task automatic test_release_checks();
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h0000_0010);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h0000_0011);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h0000_4000);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h0000_3FF0);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'hFFFF_FFFF);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd8, 13'd4, '0);
    endtask

    // new settings apply at once but leave the list alone
    task automatic test_register_update();
        apply_config(32'h8000_0000, 16'd32, 13'd16, 11'd4);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd32, 13'd16, '0);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h8000_0060);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h8000_0080);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd33, 13'd1, '0);
    endtask

    // single block pool at the top of the address space
    task automatic test_empty_pool();
        apply_config(32'hFFFF_FFF0, 16'hFFFF, 13'd4096, 11'd1);
        send_request(fbfl_pkg::MODE_CLEAR, '0, '0, '0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'hFFFF, 13'd4096, '0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd1, 13'd1, '0);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'hFFFF_FFF0);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'hFFFF_FFF0 + 32'hFFFF);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd1, 13'd1, '0);
    endtask

    // block size zero and zero blocks in use
    task automatic test_zero_sizes();
        apply_config(32'h0000_0100, 16'd0, 13'd4096, 11'd0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd1, 13'd1, '0);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h0000_0100);
        send_request(fbfl_pkg::MODE_CLEAR, '0, '0, '0);
        apply_config(32'h0000_0100, 16'd32, 13'd4096, 11'd0);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd1, 13'd1, '0);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h0000_0100);
    endtask

    // block count above the built depth is clamped
    task automatic test_blocks_clamped();
        apply_config(32'h0000_0000, 16'd8, 13'd1, 11'd2047);
        send_request(fbfl_pkg::MODE_CLEAR, '0, '0, '0);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h0000_1FF8);
        send_request(fbfl_pkg::MODE_RELEASE, '0, '0, 32'h0000_2000);
        send_request(fbfl_pkg::MODE_ALLOC, 16'd8, 13'd1, '0);
    endtask

    // receiver holds off while requests keep coming: the block must stall
    task automatic test_output_backpressure();
        apply_config(32'h0040_0000, 16'd64, 13'd64, 11'd32);
        steady_flow = 1'b1;
        send_request(fbfl_pkg::MODE_CLEAR, '0, '0, '0);
        hold_left = 300;
        for (int k = 0; k < 12; k++) begin
            send_request((k % 3 == 2) ? fbfl_pkg::MODE_RELEASE : fbfl_pkg::MODE_ALLOC,
                         16'd64, 13'd64, 32'h0040_0000 + AW'(k * 64));
        end
        steady_flow = 1'b0;
    endtask

    // random traffic on one pool setting
    task automatic test_random_traffic(input logic [AW-1:0] base,
                                       input logic [BW-1:0] size,
                                       input logic [LW-1:0] align_max,
                                       input logic [PW-1:0] count,
                                       input bit            relink,
                                       input int            items);
        apply_config(base, size, align_max, count);
        if (relink) send_request(fbfl_pkg::MODE_CLEAR, BW'($urandom()), LW'($urandom()),
                                 $urandom());
        repeat (items) random_request();
    endtask

    initial begin
        // model starts from the reset settings and the reset clear
        base_addr     = fbfl_pkg::RST_POOL_BASE;
        blk_size      = fbfl_pkg::RST_BLOCK_BYTES;
        blk_align_max = fbfl_pkg::RST_BLOCK_ALIGN;
        blk_count     = fbfl_pkg::RST_POOL_BLOCKS;
        relink_pool();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // the reset relink pass keeps the request side closed
        while (s_tready !== 1'b1) @(posedge aclk);

        test_allocation_checks();
        test_release_checks();
        test_register_update();
        test_empty_pool();
        test_zero_sizes();
        test_blocks_clamped();
        test_output_backpressure();

        // small pool that runs empty often
        test_random_traffic(32'h0000_2000, 16'd24, 13'd8, 11'd12, 1'b1, 220);
        // pool wrapping past the top of the address space, no idling at all
        steady_flow = 1'b1;
        test_random_traffic(32'hFFFF_FE00, 16'd40, 13'd1, 11'd96, 1'b1, 230);
        steady_flow = 1'b0;
        // largest blocks, largest alignment, full depth
        test_random_traffic($urandom(), 16'hFFFF, 13'd4096, 11'd1024, 1'b1, 200);
        // settings changed over a stale list
        test_random_traffic($urandom(), BW'($urandom_range(512, 1)),
                            LW'($urandom_range(4096, 1)), PW'($urandom_range(64, 1)),
                            1'b0, 200);
        // one byte blocks, one block, base at the very top
        test_random_traffic(32'hFFFF_FFFF, 16'd1, 13'd4096, 11'd1, 1'b1, 150);
        // random settings, mostly small pools
        test_random_traffic($urandom(), BW'($urandom_range(65535, 1)),
                            LW'($urandom_range(4096, 1)), PW'($urandom_range(48, 1)),
                            1'b1, 300);

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/fbfl_pkg.sv
hdl/fbfl_alu.sv
hdl/fbfl_link_mem.sv
hdl/fixed_block_free_list_allocator_top.sv
hdl/fbfl_checker.sv
verif/testbench.sv
